@@ rtl/dnsp_pkg.sv @@
// ----------------------------------------------------------------------------
// dnsp_pkg
// Shared types and constants for the DNS response field parser: item
// structs, field kind codes and the per-byte result batch.
// ----------------------------------------------------------------------------
package dnsp_pkg;

    // Most results one input byte can cause (first flag byte)
    localparam int MAX_RESULTS = 5;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    // Field kind codes
    localparam logic [4:0] KIND_ID      = 5'd0;
    localparam logic [4:0] KIND_QR      = 5'd1;
    localparam logic [4:0] KIND_OPCODE  = 5'd2;
    localparam logic [4:0] KIND_AA      = 5'd3;
    localparam logic [4:0] KIND_TC      = 5'd4;
    localparam logic [4:0] KIND_RD      = 5'd5;
    localparam logic [4:0] KIND_RA      = 5'd6;
    localparam logic [4:0] KIND_Z       = 5'd7;
    localparam logic [4:0] KIND_RCODE   = 5'd8;
    localparam logic [4:0] KIND_QDCOUNT = 5'd9;
    localparam logic [4:0] KIND_ANCOUNT = 5'd10;
    localparam logic [4:0] KIND_NSCOUNT = 5'd11;
    localparam logic [4:0] KIND_ARCOUNT = 5'd12;
    localparam logic [4:0] KIND_QNAME   = 5'd13;
    localparam logic [4:0] KIND_QTYPE   = 5'd14;
    localparam logic [4:0] KIND_QCLASS  = 5'd15;
    localparam logic [4:0] KIND_TYPE    = 5'd16;
    localparam logic [4:0] KIND_CLASS   = 5'd17;
    localparam logic [4:0] KIND_TTL     = 5'd18;
    localparam logic [4:0] KIND_RDLEN   = 5'd19;
    localparam logic [4:0] KIND_RDATA   = 5'd20;

    // Input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [4:0]  field_kind;
        logic [31:0] field_value;
        logic        run_last;
        logic        message_done;
    } t_out_item;

    // All results caused by one input byte
    typedef struct packed {
        logic [CNT_W-1:0]                  cnt;
        t_out_item [MAX_RESULTS-1:0]       items;
    } t_batch;

endpackage

@@ rtl/dnsp_decoder.sv @@
// ----------------------------------------------------------------------------
// dnsp_decoder
// Parse state (phase, byte count, accumulator, rdata count) and the
// combinational decode of one message byte into its batch of results.
// ----------------------------------------------------------------------------
module dnsp_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  dnsp_pkg::t_in_item i_item,
    output dnsp_pkg::t_batch  o_batch
);
    import dnsp_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_ID     = 5'd1,
        PH_FL1    = 5'd2,
        PH_FL2    = 5'd3,
        PH_QD     = 5'd4,
        PH_AN     = 5'd5,
        PH_NS     = 5'd6,
        PH_AR     = 5'd7,
        PH_QNAME  = 5'd8,
        PH_QTYPE  = 5'd9,
        PH_QCLASS = 5'd10,
        PH_ANAME  = 5'd11,
        PH_TYPE   = 5'd12,
        PH_CLASS  = 5'd13,
        PH_TTL    = 5'd14,
        PH_RDLEN  = 5'd15,
        PH_RDATA  = 5'd16,
        PH_DONE   = 5'd17
    } t_phase;

    function automatic t_out_item mk_item(input logic [4:0] kind, input logic [31:0] value,
                                          input logic last, input logic done);
        t_out_item it;
        it.field_kind   = kind;
        it.field_value  = value;
        it.run_last     = last;
        it.message_done = done;
        return it;
    endfunction

    t_phase      r_phase, n_phase, e_phase;
    logic [1:0]  r_bif, n_bif, e_bif;
    logic [31:0] r_acc, n_acc, e_acc;
    logic [15:0] r_rem, n_rem, e_rem;

    logic [7:0]  w_b;
    logic [31:0] w_acc_sh;
    logic        w_col_done;
    logic [4:0]  w_kind;
    t_phase      w_next;
    logic [15:0] w_rem_dec;

    assign w_b = i_item.data_byte;

    // Kind and successor of the fixed-length fields
    always_comb begin
        w_kind = KIND_ID;
        w_next = PH_FL1;
        case (e_phase)
            PH_ID:     begin w_kind = KIND_ID;      w_next = PH_FL1;    end
            PH_QD:     begin w_kind = KIND_QDCOUNT; w_next = PH_AN;     end
            PH_AN:     begin w_kind = KIND_ANCOUNT; w_next = PH_NS;     end
            PH_NS:     begin w_kind = KIND_NSCOUNT; w_next = PH_AR;     end
            PH_AR:     begin w_kind = KIND_ARCOUNT; w_next = PH_QNAME;  end
            PH_QTYPE:  begin w_kind = KIND_QTYPE;   w_next = PH_QCLASS; end
            PH_QCLASS: begin w_kind = KIND_QCLASS;  w_next = PH_ANAME;  end
            PH_TYPE:   begin w_kind = KIND_TYPE;    w_next = PH_CLASS;  end
            PH_CLASS:  begin w_kind = KIND_CLASS;   w_next = PH_TTL;    end
            PH_TTL:    begin w_kind = KIND_TTL;     w_next = PH_RDLEN;  end
            default:   begin w_kind = KIND_ID;      w_next = PH_FL1;    end
        endcase
    end

    // Decode of one byte against the current state
    always_comb begin
        e_phase = r_phase;
        e_bif   = r_bif;
        e_acc   = r_acc;
        e_rem   = r_rem;
        // start restarts the parse with this byte as the first id byte
        if (i_item.start_req) begin
            e_phase = PH_ID;
            e_bif   = 2'd0;
            e_acc   = '0;
            e_rem   = '0;
        end

        n_phase = e_phase;
        n_bif   = e_bif;
        n_acc   = e_acc;
        n_rem   = e_rem;
        o_batch = '0;

        w_acc_sh   = {e_acc[23:0], w_b};
        w_col_done = (e_phase == PH_TTL) ? (e_bif == 2'd3) : (e_bif != 2'd0);
        w_rem_dec  = e_rem - 16'd1;

        case (e_phase)
            PH_ID, PH_QD, PH_AN, PH_NS, PH_AR, PH_QTYPE, PH_QCLASS,
            PH_TYPE, PH_CLASS, PH_TTL: begin
                if (w_col_done) begin
                    n_bif   = 2'd0;
                    n_acc   = '0;
                    n_phase = w_next;
                    o_batch.cnt      = CNT_W'(1);
                    o_batch.items[0] = mk_item(w_kind,
                        (e_phase == PH_TTL) ? w_acc_sh : {16'd0, w_acc_sh[15:0]},
                        1'b1, 1'b0);
                end else begin
                    n_bif = e_bif + 2'd1;
                    n_acc = w_acc_sh;
                end
            end
            PH_FL1: begin
                o_batch.cnt      = CNT_W'(5);
                o_batch.items[0] = mk_item(KIND_QR,     {31'd0, w_b[7]},   1'b0, 1'b0);
                o_batch.items[1] = mk_item(KIND_OPCODE, {28'd0, w_b[6:3]}, 1'b0, 1'b0);
                o_batch.items[2] = mk_item(KIND_AA,     {31'd0, w_b[2]},   1'b0, 1'b0);
                o_batch.items[3] = mk_item(KIND_TC,     {31'd0, w_b[1]},   1'b0, 1'b0);
                o_batch.items[4] = mk_item(KIND_RD,     {31'd0, w_b[0]},   1'b1, 1'b0);
                n_phase = PH_FL2;
            end
            PH_FL2: begin
                o_batch.cnt      = CNT_W'(3);
                o_batch.items[0] = mk_item(KIND_RA,    {31'd0, w_b[7]},   1'b0, 1'b0);
                o_batch.items[1] = mk_item(KIND_Z,     {29'd0, w_b[6:4]}, 1'b0, 1'b0);
                o_batch.items[2] = mk_item(KIND_RCODE, {28'd0, w_b[3:0]}, 1'b1, 1'b0);
                n_phase = PH_QD;
            end
            PH_QNAME: begin
                // label bytes pass through; the zero byte ends the name
                o_batch.cnt      = CNT_W'(1);
                o_batch.items[0] = mk_item(KIND_QNAME, {24'd0, w_b}, 1'b1, 1'b0);
                if (w_b == 8'd0) begin
                    n_phase = PH_QTYPE;
                end
            end
            PH_ANAME: begin
                // compressed answer name, skipped
                if (w_col_done) begin
                    n_bif   = 2'd0;
                    n_acc   = '0;
                    n_phase = PH_TYPE;
                end else begin
                    n_bif = e_bif + 2'd1;
                    n_acc = w_acc_sh;
                end
            end
            PH_RDLEN: begin
                if (w_col_done) begin
                    n_bif = 2'd0;
                    n_acc = '0;
                    n_rem = w_acc_sh[15:0];
                    o_batch.cnt      = CNT_W'(1);
                    o_batch.items[0] = mk_item(KIND_RDLEN, {16'd0, w_acc_sh[15:0]},
                                               1'b1, w_acc_sh[15:0] == 16'd0);
                    n_phase = (w_acc_sh[15:0] == 16'd0) ? PH_DONE : PH_RDATA;
                end else begin
                    n_bif = e_bif + 2'd1;
                    n_acc = w_acc_sh;
                end
            end
            PH_RDATA: begin
                n_rem = w_rem_dec;
                o_batch.cnt      = CNT_W'(1);
                o_batch.items[0] = mk_item(KIND_RDATA, {24'd0, w_b}, 1'b1,
                                           w_rem_dec == 16'd0);
                if (w_rem_dec == 16'd0) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
                // idle or finished: byte ignored
            end
        endcase
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bif   <= 2'd0;
            r_acc   <= '0;
            r_rem   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_bif   <= n_bif;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
        end
    end

endmodule

@@ rtl/dnsp_serializer.sv @@
// ----------------------------------------------------------------------------
// dnsp_serializer
// Holds the batch of results of one byte and hands them out one item per
// output handshake. Takes the next batch in the cycle its last item leaves.
// ----------------------------------------------------------------------------
module dnsp_serializer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  dnsp_pkg::t_batch    i_batch,
    output logic                o_can_load,
    output logic                o_valid,
    input  logic                i_ready,
    output dnsp_pkg::t_out_item o_item
);
    import dnsp_pkg::*;

    t_batch            r_batch;
    logic              r_busy;
    logic [IDX_W-1:0]  r_idx;
    logic              w_last;
    logic              w_take;

    assign w_last     = (CNT_W'(r_idx) == r_batch.cnt - CNT_W'(1));
    assign w_take     = r_busy & i_ready;
    assign o_can_load = !r_busy || (w_take && w_last);
    assign o_valid    = r_busy;
    assign o_item     = r_batch.items[r_idx];

    // Batch register, no reset on payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_batch <= i_batch;
        end
    end

    // Item pointer and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= (i_batch.cnt != '0);
            r_idx  <= '0;
        end else if (w_take) begin
            if (w_last) begin
                r_busy <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // A held batch is never empty and the pointer stays inside it
    a_busy_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_batch.cnt != '0) && (CNT_W'(r_idx) < r_batch.cnt))
        else $error("serializer pointer outside batch");

    // A non-final item taken leaves another one pending
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !w_last && !i_load) |=> o_valid)
        else $error("batch dropped before its last item");

    // run_last marks exactly the final item of a batch
    a_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_item.run_last == w_last))
        else $error("run_last does not match batch end");

    // A load never overwrites pending items
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && r_busy) |-> (w_take && w_last))
        else $error("batch overwritten while pending");

endmodule

@@ rtl/dns_response_field_parser_unit.sv @@
// ----------------------------------------------------------------------------
// dns_response_field_parser_unit
// An accepted byte's first result is registered and shown in the next cycle.
// Throughput: one byte per cycle while each byte gives at most one result
//   and the receiver is ready; a byte with more holds the input until its
//   last is taken (first flag byte: 5, second: 3) by the single output port.
// Bytes that give no result (idle, answer name, partial fields) hold nothing.
// Reset (synchronous, active low): parser idle, result register empty.
// ----------------------------------------------------------------------------
module dns_response_field_parser_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dnsp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dnsp_pkg::t_out_item o_out_item
);
    import dnsp_pkg::*;

    t_batch w_batch;
    logic   w_accept;
    logic   w_can_load;

    assign o_in_ready = w_can_load;
    assign w_accept   = i_in_valid & w_can_load;

    // Byte decode and parse state
    dnsp_decoder u_decoder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_item),
        .o_batch  (w_batch)
    );

    // Result register and item sequencing
    dnsp_serializer u_serializer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_batch    (w_batch),
        .o_can_load (w_can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out_item)
    );

    // End of message is always the last result of its byte
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.message_done) |-> o_out_item.run_last)
        else $error("message_done on a non-final result");

    // Only rdlength or rdata results end a message
    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.message_done) |->
        (o_out_item.field_kind == KIND_RDLEN || o_out_item.field_kind == KIND_RDATA))
        else $error("message_done on unexpected field kind");

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DNS response field parser. A byte queue holds
// a directed opening and randomized response messages (well-formed, cut
// short, restarted, with trailing junk). A clocked driver offers the bytes
// with random gaps, a parser predictor builds the expected results as bytes
// are accepted, and a monitor checks each result field by field under a
// randomly stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dnsp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 280;
    localparam int OPENING_LEN  = 23;
    localparam int HOLD_CYCLES  = 160;
    localparam int HOLD_AT_BYTE = 100;
    localparam int SETTLE       = 16;

    // Parser phases, in message order
    typedef enum logic [4:0] {
        ST_IDLE     = 5'd0,
        ST_ID       = 5'd1,
        ST_FLAGS_HI = 5'd2,
        ST_FLAGS_LO = 5'd3,
        ST_QDCOUNT  = 5'd4,
        ST_ANCOUNT  = 5'd5,
        ST_NSCOUNT  = 5'd6,
        ST_ARCOUNT  = 5'd7,
        ST_QNAME    = 5'd8,
        ST_QTYPE    = 5'd9,
        ST_QCLASS   = 5'd10,
        ST_ANAME    = 5'd11,
        ST_TYPE     = 5'd12,
        ST_CLASS    = 5'd13,
        ST_TTL      = 5'd14,
        ST_RDLEN    = 5'd15,
        ST_RDATA    = 5'd16,
        ST_DONE     = 5'd17
    } parse_st_e;

    // One byte waiting to be sent; the flag makes the sender drain first
    typedef struct {
        t_in_item item;
        bit       wait_for_drain;
    } pending_byte_t;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    pending_byte_t pending_bytes [$];
    t_out_item     expected_fields [$];

    // Predictor state
    parse_st_e   parse_st = ST_IDLE;
    logic [1:0]  fld_bytes = '0;
    logic [31:0] fld_acc = '0;
    logic [15:0] rdata_left = '0;

    int unsigned mismatches = 0;
    int unsigned bytes_taken = 0;
    int unsigned results_taken = 0;
    int unsigned cycles = 0;
    int unsigned send_gap = 0;
    int unsigned bytes_sent = 0;
    int unsigned recv_gap = 0;
    int unsigned hold_left = 0;
    bit          hold_used = 1'b0;
    logic        in_fire_q = 1'b0;
    logic        out_fire_q = 1'b0;

    dns_response_field_parser_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] seen);
        mismatches++;
        $display("%0t: %s mismatch, want 0x%0h, saw 0x%0h", $realtime, what, want, seen);
    endtask

    function automatic void push_byte(input logic [7:0] b, input bit first,
                                      input bit drain);
        pending_byte_t e;
        e.item.data_byte = b;
        e.item.start_req = first;
        e.wait_for_drain = drain;
        pending_bytes.push_back(e);
    endfunction

    function automatic void push_field(input logic [4:0] kind, input logic [31:0] value,
                                       input logic done);
        t_out_item r;
        r.field_kind   = kind;
        r.field_value  = value;
        r.run_last     = 1'b0;
        r.message_done = done;
        expected_fields.push_back(r);
    endfunction

    // Parser predictor: appends the fields one accepted byte completes
    task automatic decode_byte(input t_in_item it);
        logic [7:0]  b;
        logic [4:0]  kind;
        int unsigned first;
        t_out_item   last;
        b = it.data_byte;
        first = expected_fields.size();
        if (it.start_req) begin
            parse_st   = ST_ID;
            fld_bytes  = '0;
            fld_acc    = '0;
            rdata_left = '0;
        end
        case (parse_st)
            ST_ID, ST_QDCOUNT, ST_ANCOUNT, ST_NSCOUNT, ST_ARCOUNT, ST_QTYPE, ST_QCLASS,
            ST_ANAME, ST_TYPE, ST_CLASS, ST_TTL, ST_RDLEN: begin
                // big-endian collection; ttl takes four bytes, the rest two
                fld_acc = {fld_acc[23:0], b};
                if (fld_bytes == ((parse_st == ST_TTL) ? 2'd3 : 2'd1)) begin
                    fld_bytes = '0;
                    case (parse_st)
                        ST_ANAME: parse_st = ST_TYPE;
                        ST_RDLEN: begin
                            rdata_left = fld_acc[15:0];
                            push_field(KIND_RDLEN, {16'h0, fld_acc[15:0]},
                                       fld_acc[15:0] == 16'h0);
                            parse_st = (fld_acc[15:0] == 16'h0) ? ST_DONE : ST_RDATA;
                        end
                        default: begin
                            if (parse_st == ST_ID)
                                kind = KIND_ID;
                            else if (parse_st <= ST_ARCOUNT)
                                kind = KIND_QDCOUNT + 5'(parse_st - ST_QDCOUNT);
                            else if (parse_st <= ST_QCLASS)
                                kind = KIND_QTYPE + 5'(parse_st - ST_QTYPE);
                            else
                                kind = KIND_TYPE + 5'(parse_st - ST_TYPE);
                            push_field(kind, (parse_st == ST_TTL) ? fld_acc
                                                                  : {16'h0, fld_acc[15:0]},
                                       1'b0);
                            parse_st = (parse_st == ST_QCLASS) ? ST_ANAME
                                                               : parse_st_e'(parse_st + 5'd1);
                        end
                    endcase
                    fld_acc = '0;
                end else begin
                    fld_bytes = fld_bytes + 2'd1;
                end
            end
            ST_FLAGS_HI: begin
                push_field(KIND_QR,     {31'h0, b[7]},   1'b0);
                push_field(KIND_OPCODE, {28'h0, b[6:3]}, 1'b0);
                push_field(KIND_AA,     {31'h0, b[2]},   1'b0);
                push_field(KIND_TC,     {31'h0, b[1]},   1'b0);
                push_field(KIND_RD,     {31'h0, b[0]},   1'b0);
                parse_st = ST_FLAGS_LO;
            end
            ST_FLAGS_LO: begin
                push_field(KIND_RA,    {31'h0, b[7]},   1'b0);
                push_field(KIND_Z,     {29'h0, b[6:4]}, 1'b0);
                push_field(KIND_RCODE, {28'h0, b[3:0]}, 1'b0);
                parse_st = ST_QDCOUNT;
            end
            // name bytes pass through until the zero terminator
            ST_QNAME: begin
                push_field(KIND_QNAME, {24'h0, b}, 1'b0);
                if (b == 8'h00)
                    parse_st = ST_QTYPE;
            end
            ST_RDATA: begin
                rdata_left = rdata_left - 16'd1;
                push_field(KIND_RDATA, {24'h0, b}, rdata_left == 16'h0);
                if (rdata_left == 16'h0)
                    parse_st = ST_DONE;
            end
            default: ;
        endcase
        if (expected_fields.size() > first) begin
            last = expected_fields.pop_back();
            last.run_last = 1'b1;
            expected_fields.push_back(last);
        end
    endtask

    // One response message with random content; sometimes cut short or padded
    task automatic queue_message(input bit empty_rdata, input bit drain_first);
        logic [7:0]  msg [$];
        logic [15:0] rdlen;
        int          labels;
        int          llen;
        int          pick;
        int          n_rdata;
        repeat (12) msg.push_back(8'($urandom_range(0, 255)));
        labels = $urandom_range(0, 3);
        repeat (labels) begin
            llen = $urandom_range(1, 6);
            msg.push_back(8'(llen));
            repeat (llen) msg.push_back(8'($urandom_range(1, 255)));
        end
        msg.push_back(8'h00);
        // qtype, qclass, answer name, type, class, ttl
        repeat (14) msg.push_back(8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 15);
        if (empty_rdata || pick == 0)
            rdlen = 16'h0;
        else if (pick == 1)
            rdlen = 16'hFFFF;
        else if (pick == 2)
            rdlen = 16'($urandom_range(9, 40));
        else
            rdlen = 16'($urandom_range(1, 8));
        msg.push_back(rdlen[15:8]);
        msg.push_back(rdlen[7:0]);
        // huge rdata is never sent in full
        n_rdata = (rdlen > 16'd40) ? $urandom_range(1, 12) : int'(rdlen);
        repeat (n_rdata) msg.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, msg.size() - 1)) void'(msg.pop_back());
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom_range(0, 255)));
        foreach (msg[k])
            push_byte(msg[k], k == 0, drain_first && k == 0);
    endtask

    // Monitor: predict on accepted bytes, check accepted results
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                decode_byte(i_in_item);
                bytes_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                results_taken++;
                if (expected_fields.size() == 0) begin
                    flag_mismatch("unexpected result, kind", 32'h0,
                                  {27'h0, o_out_item.field_kind});
                end else begin
                    want = expected_fields.pop_front();
                    if (o_out_item.field_kind !== want.field_kind)
                        flag_mismatch("field_kind", want.field_kind, o_out_item.field_kind);
                    if (o_out_item.field_value !== want.field_value)
                        flag_mismatch("field_value", want.field_value,
                                      o_out_item.field_value);
                    if (o_out_item.run_last !== want.run_last)
                        flag_mismatch("run_last", want.run_last, o_out_item.run_last);
                    if (o_out_item.message_done !== want.message_done)
                        flag_mismatch("message_done", want.message_done,
                                      o_out_item.message_done);
                end
            end
            in_fire_q  <= i_in_valid && o_in_ready;
            out_fire_q <= o_out_valid && i_out_ready;
        end else begin
            in_fire_q  <= 1'b0;
            out_fire_q <= 1'b0;
        end
    end

    // Driver: next byte after a random gap; bursts without gaps now and then
    always @(negedge i_clk) begin : driver
        pending_byte_t cur;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire_q) begin
            if (send_gap != 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_bytes.size() != 0 &&
                         !(pending_bytes[0].wait_for_drain && expected_fields.size() != 0)) begin
                cur = pending_bytes.pop_front();
                i_in_item  <= cur.item;
                i_in_valid <= 1'b1;
                bytes_sent++;
                send_gap = (((bytes_sent / 48) % 3) == 1) ? 0 : $urandom_range(0, 7);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off once, while the sender keeps offering
    always @(negedge i_clk) begin : hold_off
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_used && bytes_taken >= HOLD_AT_BYTE) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // Receiver: random stall before each result, stall-free stretches too
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
        end else if (out_fire_q) begin
            recv_gap = (((results_taken / 60) % 3) == 1) ? 0 : $urandom_range(0, 7);
            i_out_ready <= (recv_gap == 0);
        end else if (recv_gap != 0) begin
            recv_gap--;
            i_out_ready <= (recv_gap == 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        logic [8:0] opening [0:OPENING_LEN-1];
        int         msg_no;
        // {start, byte}: a byte before any start, a header cut short by a
        // restart, then a header with extreme flags and counts, empty qname
        opening = '{9'h0A5,
                    9'h1FF, 9'h0FF, 9'h0FF, 9'h000, 9'h000, 9'h000,
                    9'h100, 9'h000, 9'h000, 9'h0FF, 9'h0FF, 9'h0FF, 9'h000, 9'h000,
                    9'h0FF, 9'h0FF, 9'h080, 9'h001,
                    9'h000, 9'h0FF, 9'h0FF, 9'h000};
        foreach (opening[k])
            push_byte(opening[k][7:0], opening[k][8], 1'b0);
        msg_no = 0;
        while (pending_bytes.size() < OPENING_LEN + RANDOM_BYTES) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise, with stray starts
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0);
            end else begin
                queue_message(msg_no == 0, msg_no == 4);
                msg_no++;
            end
        end

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || i_in_valid || expected_fields.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
